// ----- hdl/mm_pkg.sv -----
// shared constants, codes and control/status structs of the matrix multiplier
package mm_pkg;

    localparam int MAX_DIM_DEF = 8;   // default largest matrix dimension
    localparam int ELEM_W      = 16;  // input element width
    localparam int VALUE_W     = 35;  // product element width
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int OUT_IDX_W   = 3;   // out_row / out_col width
    localparam int REG_W       = 4;   // configuration register width
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // op field codes
    localparam logic OP_A = 1'b0;
    localparam logic OP_B = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic in_ready;  // load phase, input words taken
        logic rd;        // issue one store read and step k
        logic emit;      // move accumulator to output register, step to next element
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic complete;  // accepted word left both matrices complete
        logic k_last;    // current read is the last term of the dot product
        logic elem_last; // current element is the last of the product
        logic busy;      // multiply-accumulate pipeline still holds terms
        logic out_free;  // output register can take a word this cycle
    } t_status;

endpackage

// ----- hdl/mm_if.sv -----
// handshake channels: element input words and product output words

interface mm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [mm_pkg::ELEM_W-1:0]  element;

    modport source (output valid, output op, output element, input ready);
    modport sink   (input valid, input op, input element, output ready);
endinterface

interface mm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mm_pkg::VALUE_W-1:0]    product_value;
    logic        [mm_pkg::OUT_IDX_W-1:0]  out_row;
    logic        [mm_pkg::OUT_IDX_W-1:0]  out_col;
    logic                                 last;

    modport source (output valid, output product_value, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input product_value, input out_row, input out_col,
                    input last, output ready);
endinterface

// ----- hdl/mm_ctrl.sv -----
// sequencing state machine: load, dot product reads, drain and emit
module mm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mm_pkg::t_status i_status,
    output mm_pkg::t_cmd    o_cmd
);
    import mm_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.complete) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.rd = 1'b1;
                if (i_status.k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy && i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.elem_last ? ST_LOAD : ST_RUN;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/mm_dp.sv -----
// datapath: dimension registers, element stores, load counts, index walk,
// multiply-accumulate pipeline and output register
module mm_dp #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mm_pkg::REG_W-1:0]      i_cfg_data,
    mm_in_if.sink                         i_in,
    mm_out_if.source                      o_out,
    input  mm_pkg::t_cmd                  i_cmd,
    output mm_pkg::t_status               o_status
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IW    = $clog2(MAX_DIM);

    // configuration registers
    logic [REG_W-1:0] r_rows_a;
    logic [REG_W-1:0] r_inner_dim;
    logic [REG_W-1:0] r_cols_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= REG_W'(1);
            r_inner_dim <= REG_W'(1);
            r_cols_b    <= REG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // zero is taken as one, anything above MAX_DIM as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_W-1:0] raw);
        logic [DIM_W-1:0] d;
        if (raw == '0) begin
            d = DIM_W'(1);
        end else if (int'(raw) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(raw);
        end
        return d;
    endfunction

    logic [DIM_W-1:0] ra, kd, cb;
    logic [CNT_W-1:0] size_a, size_b;

    assign ra     = eff_dim(r_rows_a);
    assign kd     = eff_dim(r_inner_dim);
    assign cb     = eff_dim(r_cols_b);
    assign size_a = CNT_W'(ra) * CNT_W'(kd);
    assign size_b = CNT_W'(kd) * CNT_W'(cb);

    // load side
    logic             accept, wr_a, wr_b, complete;
    logic [CNT_W-1:0] r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;

    assign i_in.ready = i_cmd.in_ready;
    assign accept     = i_in.valid && i_cmd.in_ready;
    assign wr_a       = accept && (i_in.op == OP_A) && (r_cnt_a < size_a);
    assign wr_b       = accept && (i_in.op == OP_B) && (r_cnt_b < size_b);
    assign n_cnt_a    = r_cnt_a + CNT_W'(wr_a);
    assign n_cnt_b    = r_cnt_b + CNT_W'(wr_b);
    assign complete   = accept && (n_cnt_a >= size_a) && (n_cnt_b >= size_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else if (complete) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
        end
    end

    // index walk over product elements and dot product terms
    logic [IW-1:0]    r_i, r_j, r_k;
    logic [IDX_W-1:0] r_a_base, r_b_addr;
    logic             k_last, j_last, elem_last;
    logic [IDX_W-1:0] a_addr;

    assign a_addr    = r_a_base + IDX_W'(r_k);
    assign k_last    = (DIM_W'(r_k) == kd - DIM_W'(1));
    assign j_last    = (DIM_W'(r_j) == cb - DIM_W'(1));
    assign elem_last = j_last && (DIM_W'(r_i) == ra - DIM_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_b_addr <= '0;
        end else if (complete) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_b_addr <= '0;
        end else if (i_cmd.rd) begin
            r_k      <= r_k + IW'(1);
            r_b_addr <= r_b_addr + IDX_W'(cb);
        end else if (i_cmd.emit && !elem_last) begin
            r_k <= '0;
            if (j_last) begin
                r_j      <= '0;
                r_i      <= r_i + IW'(1);
                r_a_base <= r_a_base + IDX_W'(kd);
                r_b_addr <= '0;
            end else begin
                r_j      <= r_j + IW'(1);
                r_b_addr <= IDX_W'(r_j) + IDX_W'(1);
            end
        end
    end

    // element stores, registered reads
    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];
    logic signed [ELEM_W-1:0] r_rd_a, r_rd_b;

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[r_cnt_a[IDX_W-1:0]] <= i_in.element;
        end
        if (i_cmd.rd) begin
            r_rd_a <= mem_a[a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[r_cnt_b[IDX_W-1:0]] <= i_in.element;
        end
        if (i_cmd.rd) begin
            r_rd_b <= mem_b[r_b_addr];
        end
    end

    // read -> multiply -> accumulate
    logic                      r_v1, r_v2, r_first1, r_first2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [VALUE_W-1:0] r_acc, acc_base, prod_ext;

    assign acc_base = r_first2 ? VALUE_W'(0) : r_acc;
    assign prod_ext = VALUE_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_first2 <= r_first1;
        r_prod   <= r_rd_a * r_rd_b;
        if (r_v2) begin
            r_acc <= acc_base + prod_ext;
        end
    end

    // output register
    logic                       r_out_valid;
    logic                       out_free;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic [OUT_IDX_W-1:0]       r_out_row, r_out_col;
    logic                       r_out_last;

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value <= r_acc;
            r_out_row   <= OUT_IDX_W'(r_i);
            r_out_col   <= OUT_IDX_W'(r_j);
            r_out_last  <= elem_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.product_value = r_out_value;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.last          = r_out_last;

    assign o_status.complete  = complete;
    assign o_status.k_last    = k_last;
    assign o_status.elem_last = elem_last;
    assign o_status.busy      = r_v1 || r_v2;
    assign o_status.out_free  = out_free;

endmodule

// ----- hdl/matrix_multiply_top.sv -----
// top level of the signed integer matrix multiplier
//
// channel   dir  handshake       word contents
// i_in      in   valid / ready   op (0 = A, 1 = B), element (signed 16)
// o_out     out  valid / ready   product_value (signed 35), out_row, out_col, last
// i_cfg_*   in   write enable    register index (rows_a, inner_dim, cols_b), 4-bit data
//
// load: one input word per cycle; the word that completes both matrices starts the run
// run: each product element takes one store read per term, then the read, multiply and
//   accumulate stages drain through one mac unit before the element is emitted;
//   no input is taken during a run
// the output register lets an element be computed while the previous one waits;
//   a stalled output holds the mac in its drain step
// reset is synchronous, active low: dimensions go to 1, load counts to 0,
//   stores are not cleared
module matrix_multiply_top #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mm_pkg::REG_W-1:0]      i_cfg_data,
    mm_in_if.sink                         i_in,
    mm_out_if.source                      o_out
);
    import mm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // fsm: load / run / drain
    mm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // stores, counters, mac pipeline, output register
    mm_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// testbench of the matrix multiplier: scoreboarded element loads and product words
module tb;
    import mm_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEF;
    localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
    localparam int RANDOM_WORDS = 175;   // directed words and job overshoot add the rest
    localparam int SETTLE_CYC   = 20;    // idle time after the last product word
    localparam int TAIL_CYC     = 60;    // quiet time before the verdict
    localparam int TIMEOUT_NS   = 20_000_000;

    // writes to this index land on no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                     op;
        logic signed [ELEM_W-1:0] element;
    } t_elem_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0]   value;
        logic        [OUT_IDX_W-1:0] row;
        logic        [OUT_IDX_W-1:0] col;
        logic                        last;
    } t_product_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_data;

    mm_in_if  in_ch ();
    mm_out_if out_ch ();

    matrix_multiply_top #(.MAX_DIM(MAX_DIM)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // shadow copy of the block: raw registers, element stores and load counts
    logic [REG_W-1:0]         dim_rows;
    logic [REG_W-1:0]         dim_inner;
    logic [REG_W-1:0]         dim_cols;
    logic signed [ELEM_W-1:0] a_store [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_store [STORE_DEPTH];
    int unsigned              a_count;
    int unsigned              b_count;

    t_elem_word    element_q [$];   // words waiting for the driver
    t_product_word product_q [$];   // product words still owed by the block

    int  fail_count;
    int  idle_pct;                  // chance the sender holds off a cycle
    int  stall_pct;                 // chance the receiver drops ready
    logic in_taken;                 // input word accepted at the last rising edge

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb NOT OK");
        $finish;
    end

    // register value 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic int unsigned used_dim(input logic [REG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return raw;
    endfunction

    // one accepted element: store it unless its matrix is full, and once both
    // matrices are complete queue the whole product in row-major order
    task automatic load_element(input logic op, input logic signed [ELEM_W-1:0] e);
        int unsigned              ra;
        int unsigned              kd;
        int unsigned              cb;
        logic signed [VALUE_W-1:0] acc;
        logic signed [PROD_W-1:0]  term;
        t_product_word            w;
        ra = used_dim(dim_rows);
        kd = used_dim(dim_inner);
        cb = used_dim(dim_cols);
        if (op == OP_A) begin
            if (a_count < ra * kd) begin
                a_store[a_count % STORE_DEPTH] = e;
                a_count++;
            end
        end else begin
            if (b_count < kd * cb) begin
                b_store[b_count % STORE_DEPTH] = e;
                b_count++;
            end
        end
        // completeness is judged under the dimensions in force right now
        if (a_count >= ra * kd && b_count >= kd * cb) begin
            for (int unsigned i = 0; i < ra; i++) begin
                for (int unsigned j = 0; j < cb; j++) begin
                    acc = '0;
                    for (int unsigned k = 0; k < kd; k++) begin
                        term = a_store[(i * kd + k) % STORE_DEPTH] *
                               b_store[(k * cb + j) % STORE_DEPTH];
                        acc += term;
                    end
                    w.value = acc;
                    w.row   = i[OUT_IDX_W-1:0];
                    w.col   = j[OUT_IDX_W-1:0];
                    w.last  = (i + 1 == ra) && (j + 1 == cb);
                    product_q.push_back(w);
                end
            end
            a_count = 0;
            b_count = 0;
        end
    endtask

    task automatic check_product();
        t_product_word want;
        if (product_q.size() == 0) begin
            $error("unexpected product word: value %0d row %0d col %0d last %0b",
                   out_ch.product_value, out_ch.out_row, out_ch.out_col, out_ch.last);
            fail_count++;
        end else begin
            want = product_q.pop_front();
            if (out_ch.product_value !== want.value) begin
                $error("product_value: expected %0d, got %0d", want.value,
                       out_ch.product_value);
                fail_count++;
            end
            if (out_ch.out_row !== want.row) begin
                $error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
                fail_count++;
            end
            if (out_ch.out_col !== want.col) begin
                $error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
                fail_count++;
            end
            if (out_ch.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, out_ch.last);
                fail_count++;
            end
        end
    endtask

    // monitor: everything sampled at the rising edge, inputs before outputs
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            load_element(in_ch.op, in_ch.element);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            check_product();
    end

    // driver: a word stays on the bus until taken, then the next one may follow
    always @(negedge i_clk) begin
        t_elem_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (element_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                w = element_q.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.op      <= w.op;
                in_ch.element <= w.element;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure on the product channel
    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // register write, only called while the block is idle, so the shadow copy
    // can follow right away
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            REG_ROWS_A:    dim_rows  = val;
            REG_INNER_DIM: dim_inner = val;
            REG_COLS_B:    dim_cols  = val;
            default: ;
        endcase
    endtask

    task automatic send(input logic op, input logic signed [ELEM_W-1:0] e);
        t_elem_word w;
        w.op      = op;
        w.element = e;
        element_q.push_back(w);
    endtask

    // hold the sender until every word went out and every product came back,
    // then give the block a little more time before touching the registers
    task automatic drain();
        while (element_q.size() != 0 || in_ch.valid || product_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // idling profiles: none, sender only, receiver only, both
    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 38; stall_pct = 38; end
        endcase
    endtask

    // four times in ten the extremes of the element range, zero or all ones, else any 16-bit pattern
    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return ELEM_W'($urandom_range(16'hffff));
        endcase
    endfunction

    // small sizes most of the time, now and then the largest or out of range
    function automatic logic [REG_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        if (r < 8)
            return REG_W'($urandom_range(9, 15));
        if (r < 14)
            return REG_W'(MAX_DIM);
        return REG_W'($urandom_range(1, 4));
    endfunction

    initial begin
        int unsigned need_a;
        int unsigned need_b;
        int unsigned stop_at;
        int unsigned sent;
        int unsigned n;
        int          job;
        logic        op;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.op      = OP_A;
        in_ch.element = '0;
        out_ch.ready  = 1'b0;
        in_taken      = 1'b0;
        fail_count    = 0;
        dim_rows      = 4'd1;
        dim_inner     = 4'd1;
        dim_cols      = 4'd1;
        a_count       = 0;
        b_count       = 0;
        set_idling(0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part ----
        // reset dimensions 1x1x1: most negative squared
        send(OP_A, 16'sh8000);
        send(OP_B, 16'sh8000);
        drain();

        // zero in every register acts as one
        set_reg(REG_ROWS_A, 4'd0);
        set_reg(REG_INNER_DIM, 4'd0);
        set_reg(REG_COLS_B, 4'd0);
        send(OP_A, 16'sh7fff);
        send(OP_B, 16'sh8000);
        drain();

        // 1x2x1 with a third A word for a full matrix, which must be dropped
        set_reg(REG_ROWS_A, 4'd1);
        set_reg(REG_INNER_DIM, 4'd2);
        set_reg(REG_COLS_B, 4'd1);
        send(OP_A, 16'sh7fff);
        send(OP_A, -16'sd3);
        send(OP_A, 16'sh1234);
        send(OP_B, 16'sh7fff);
        send(OP_B, 16'sh0005);
        drain();

        // dimensions shrink mid-load: 2x2x2 partly loaded, then inner goes to 1,
        // and the next word (dropped itself) finds both matrices complete
        set_reg(REG_INNER_DIM, 4'd2);
        set_reg(REG_COLS_B, 4'd2);
        set_reg(REG_ROWS_A, 4'd2);
        send(OP_A, 16'sh0007);
        send(OP_A, -16'sd11);
        send(OP_A, 16'sh8000);
        send(OP_B, 16'sh0003);
        send(OP_B, -16'sd2);
        drain();
        set_reg(REG_INNER_DIM, 4'd1);
        send(OP_B, 16'sh4000);
        drain();

        // write to the unused index, then 15 rows (acts as the maximum) by 1 by 1
        set_reg(REG_UNUSED, 4'hf);
        set_reg(REG_ROWS_A, 4'hf);
        set_reg(REG_COLS_B, 4'd1);
        for (int i = 0; i < MAX_DIM; i++)
            send(OP_A, (i % 2 == 0) ? 16'sh8000 : 16'sh7fff);
        send(OP_B, 16'sh8000);
        drain();

        // ---- random part ----
        // each job: idle the block, pick new dimensions, then load what is still
        // missing under them; a few jobs stop short so the next one changes the
        // dimensions mid-load, and a few words go to an already full matrix
        sent = 0;
        job  = 0;
        while (sent < RANDOM_WORDS) begin
            drain();
            set_idling(job);
            job++;
            set_reg(REG_ROWS_A, pick_dim());
            set_reg(REG_INNER_DIM, pick_dim());
            set_reg(REG_COLS_B, pick_dim());
            need_a = used_dim(dim_rows) * used_dim(dim_inner);
            need_b = used_dim(dim_inner) * used_dim(dim_cols);
            need_a = (a_count < need_a) ? need_a - a_count : 0;
            need_b = (b_count < need_b) ? need_b - b_count : 0;

            if (need_a + need_b == 0) begin
                // both already complete under the new sizes: any word starts the run
                send(logic'($urandom_range(1)), pick_element());
                sent++;
                continue;
            end

            stop_at = need_a + need_b;
            if (stop_at > 1 && $urandom_range(99) < 12)
                stop_at = $urandom_range(1, stop_at - 1);

            n = 0;
            while (n < stop_at) begin
                // stray word for a matrix that is already full
                if ((need_a == 0 || need_b == 0) && $urandom_range(99) < 6)
                    send((need_a == 0) ? OP_A : OP_B, pick_element());
                if (need_a == 0)
                    op = OP_B;
                else if (need_b == 0)
                    op = OP_A;
                else
                    op = ($urandom_range(1) == 0) ? OP_A : OP_B;
                send(op, pick_element());
                if (op == OP_A)
                    need_a--;
                else
                    need_b--;
                n++;
                sent++;
            end
        end

        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (fail_count == 0 && product_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
